/* rtl/diff_drive_odometry_with_reset_core_defines.svh */
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared assertion forms for the odometry core. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_WITH_RESET_CORE_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_WITH_RESET_CORE_DEFINES_SVH

// same-cycle implication
`define ODO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ODO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/odo_pkg.sv */
// ----------------------------------------------------------------------------
// Odometry package
// Types, constants and the CORDIC arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int CW        = 34;
  localparam int QDEPTH    = 2;

  localparam logic [29:0]          RAD_TO_BAM   = 30'd683565276;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032875;

  localparam logic [15:0] RADIUS_RST  = 16'd2785;
  localparam logic [15:0] PERIOD_RST  = 16'd3277;
  localparam logic [31:0] GAIN_RST    = 32'd8326;
  localparam logic [31:0] POS_X_RST   = 32'd3612;
  localparam logic [31:0] POS_Y_RST   = 32'hFFFF_FFE0;
  localparam logic [31:0] HEADING_RST = 32'd6835653;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_CORRECT = 1'b1
  } odo_op_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_PERIOD = 2'd1,
    REG_GAIN   = 2'd2,
    REG_NONE   = 2'd3
  } odo_reg_t;

  // a/b: wheel speeds or new x/y, c: new heading
  typedef struct packed {
    odo_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } odo_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* rtl/diff_drive_odometry_with_reset_core.sv */
// ----------------------------------------------------------------------------
// Differential-drive odometry core
// Dead-reckoning pose integration from wheel speeds, with pose correction.
// ----------------------------------------------------------------------------
// The integration path of a wheel sample runs registered multiply steps
// and then two passes through one iterative CORDIC, one for the new heading
// and one for the half-heading quaternion. A pose correction returns
// nothing; the sample after it reports the pose without moving it.
// A two-entry queue takes new requests while the back end is busy, and the
// result register holds a finished pose until it is taken.
module diff_drive_odometry_with_reset_core
  import odo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_left_wheel_speed,
  input  logic [31:0] in_right_wheel_speed,
  input  logic [31:0] in_new_x,
  input  logic [31:0] in_new_y,
  input  logic [31:0] in_new_heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pose_x,
  output logic [31:0] out_pose_y,
  output logic [31:0] out_pose_heading,
  output logic [15:0] out_quat_z,
  output logic [15:0] out_quat_w,
  output logic        out_was_integrated,
  output logic        out_saturated
);

  logic [15:0] radius_r, period_r;
  logic [31:0] gain_r;
  odo_reg_t    ridx;
  logic        wr;
  logic        item_valid, pop;
  odo_item_t   item;

  assign pready = 1'b1;
  assign ridx   = odo_reg_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      period_r <= PERIOD_RST;
      gain_r   <= GAIN_RST;
    end else if (wr) begin
      case (ridx)
        REG_RADIUS: radius_r <= pwdata[15:0];
        REG_PERIOD: period_r <= pwdata[15:0];
        REG_GAIN:   gain_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_RADIUS: prdata = {16'b0, radius_r};
      REG_PERIOD: prdata = {16'b0, period_r};
      REG_GAIN:   prdata = gain_r;
      default:    prdata = '0;
    endcase
  end

  odo_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_left_wheel_speed  (in_left_wheel_speed),
    .in_right_wheel_speed (in_right_wheel_speed),
    .in_new_x             (in_new_x),
    .in_new_y             (in_new_y),
    .in_new_heading       (in_new_heading),
    .pop                  (pop),
    .item_valid           (item_valid),
    .item                 (item)
  );

  odo_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wheel_radius       (radius_r),
    .sample_period      (period_r),
    .heading_gain       (gain_r),
    .item_valid         (item_valid),
    .item               (item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pose_x         (out_pose_x),
    .out_pose_y         (out_pose_y),
    .out_pose_heading   (out_pose_heading),
    .out_quat_z         (out_quat_z),
    .out_quat_w         (out_quat_w),
    .out_was_integrated (out_was_integrated),
    .out_saturated      (out_saturated)
  );

endmodule

/* rtl/odo_front.sv */
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts requests, sorts them into sample or correction entries, and
// queues them for the back end.
// ----------------------------------------------------------------------------
module odo_front
  import odo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_left_wheel_speed,
  input  logic [31:0] in_right_wheel_speed,
  input  logic [31:0] in_new_x,
  input  logic [31:0] in_new_y,
  input  logic [31:0] in_new_heading,
  input  logic        pop,
  output logic        item_valid,
  output odo_item_t   item
);

  localparam int PW = $clog2(QDEPTH);

  odo_item_t       q_r [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  odo_item_t       ent;
  logic            push;

  assign in_ready   = (cnt_r != (PW+1)'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];

  always_comb begin
    ent.op = odo_op_t'(in_opcode);
    ent.a  = (ent.op == OP_CORRECT) ? in_new_x : in_left_wheel_speed;
    ent.b  = (ent.op == OP_CORRECT) ? in_new_y : in_right_wheel_speed;
    ent.c  = in_new_heading;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule

/* rtl/odo_cordic.sv */
// ----------------------------------------------------------------------------
// Odometry CORDIC
// Iterative rotation-mode CORDIC, one step per cycle, giving cosine and
// sine of a binary angle in Q4.30.
// ----------------------------------------------------------------------------
module odo_cordic
  import odo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          angle,
  output cor_stat_t            stat,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic [1:0]           q_r;
  logic [IW-1:0]        idx_r;
  logic                 busy_r, done_r;
  logic [31:0]          qsum, zfold;
  logic [1:0]           q_in;
  logic signed [CW-1:0] at;

  assign qsum  = angle + 32'h2000_0000;
  assign q_in  = qsum[31:30];
  assign zfold = angle - {q_in, 30'b0};
  assign at    = $signed({2'b00, atan_bam(5'(idx_r))});

  always_comb begin
    if (!z_r[CW-1]) begin
      x_nxt = x_r - (y_r >>> idx_r);
      y_nxt = y_r + (x_r >>> idx_r);
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + (y_r >>> idx_r);
      y_nxt = y_r - (x_r >>> idx_r);
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IW'(CORDIC_STEPS-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_START;
      y_r <= '0;
      z_r <= {{(CW-32){zfold[31]}}, zfold};
      q_r <= q_in;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    case (q_r)
      2'd0: begin
        cos_o = x_r;
        sin_o = y_r;
      end
      2'd1: begin
        cos_o = -y_r;
        sin_o = x_r;
      end
      2'd2: begin
        cos_o = -x_r;
        sin_o = -y_r;
      end
      default: begin
        cos_o = y_r;
        sin_o = -x_r;
      end
    endcase
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/odo_back.sv */
// ----------------------------------------------------------------------------
// Odometry back end
// Runs queued entries: applies corrections, integrates wheel samples and
// builds the result with the yaw quaternion.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_with_reset_core_defines.svh"

module odo_back
  import odo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] wheel_radius,
  input  logic [15:0] sample_period,
  input  logic [31:0] heading_gain,
  input  logic        item_valid,
  input  odo_item_t   item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pose_x,
  output logic [31:0] out_pose_y,
  output logic [31:0] out_pose_heading,
  output logic [15:0] out_quat_z,
  output logic [15:0] out_quat_w,
  output logic        out_was_integrated,
  output logic        out_saturated
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ARC1  = 12'b0000_0000_0010,
    S_ARC2  = 12'b0000_0000_0100,
    S_GAIN  = 12'b0000_0000_1000,
    S_RAD1  = 12'b0000_0001_0000,
    S_RAD2  = 12'b0000_0010_0000,
    S_ROTS  = 12'b0000_0100_0000,
    S_ROTW  = 12'b0000_1000_0000,
    S_MOVE  = 12'b0001_0000_0000,
    S_SATS  = 12'b0010_0000_0000,
    S_HALFS = 12'b0100_0000_0000,
    S_HALFW = 12'b1000_0000_0000
  } st_t;

  st_t st_r, st_nxt;

  logic [31:0]          pos_x_r, pos_y_r, heading_r;
  logic                 skip_r;
  logic [31:0]          spd_l_r, spd_r_r;
  logic signed [48:0]   pl_r, pr_r;
  logic signed [33:0]   al_r, ar_r;
  logic signed [33:0]   mean_r;
  logic                 neg_r;
  logic [47:0]          rad_r;
  logic [53:0]          plo_r, phi_r;
  logic signed [67:0]   mx_r, my_r;
  logic                 moved_r, clip_r;

  logic                 out_valid_r;
  logic [31:0]          o_x_r, o_y_r, o_h_r;
  logic [15:0]          o_z_r, o_w_r;
  logic                 o_int_r, o_sat_r;

  logic                 cor_start;
  logic [31:0]          cor_angle;
  cor_stat_t            cor_stat;
  logic signed [CW-1:0] cor_cos, cor_sin;

  logic signed [65:0]   tl, tr;
  logic signed [34:0]   sum_lr, diff_lr;
  logic [34:0]          mag;
  logic [63:0]          mprod;
  logic [77:0]          bprod;
  logic [31:0]          dang, head_nxt;
  logic signed [37:0]   dx, dy;
  logic signed [38:0]   nx, ny;
  logic [31:0]          sx_v, sy_v;
  logic                 cx, cy;
  logic [15:0]          qz, qw;

  function automatic logic [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0]    s;
    logic signed [CW-15:0] r;
    logic [15:0]           o;
    s = {v[CW-1], v} + (CW+1)'(16384);
    r = s[CW:15];
    if (r > (CW-14)'(32767)) begin
      o = 16'h7FFF;
    end else if (r < -(CW-14)'(32768)) begin
      o = 16'h8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] sat_pos(input logic signed [38:0] v, output logic c);
    logic [31:0] o;
    c = 1'b0;
    if (v > 39'sd2147483647) begin
      o = 32'h7FFF_FFFF;
      c = 1'b1;
    end else if (v < -39'sd2147483648) begin
      o = 32'h8000_0000;
      c = 1'b1;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  odo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .stat  (cor_stat),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  assign pop       = (st_r == S_IDLE) && item_valid &&
                     ((item.op == OP_CORRECT) || !out_valid_r);
  assign cor_start = (st_r == S_ROTS) || (st_r == S_HALFS);
  assign cor_angle = (st_r == S_HALFS) ? {heading_r[31], heading_r[31:1]} : heading_r;

  assign tl      = pl_r * $signed({1'b0, sample_period}) + 66'sd2147483648;
  assign tr      = pr_r * $signed({1'b0, sample_period}) + 66'sd2147483648;
  assign sum_lr  = 35'(al_r) + 35'(ar_r);
  assign diff_lr = 35'(ar_r) - 35'(al_r);
  assign mag     = diff_lr[34] ? 35'(-diff_lr) : 35'(diff_lr);
  assign mprod   = mag[31:0] * heading_gain;
  assign bprod   = {24'b0, plo_r} + {phi_r, 24'b0};
  assign dang    = bprod[FRAC_BITS+31:FRAC_BITS];
  assign head_nxt = heading_r + (neg_r ? (32'd0 - dang) : dang);

  assign dx = 38'((mx_r + 68'sd536870912) >>> 30);
  assign dy = 38'((my_r + 68'sd536870912) >>> 30);
  assign nx = $signed({{7{pos_x_r[31]}}, pos_x_r}) + 39'(dx);
  assign ny = $signed({{7{pos_y_r[31]}}, pos_y_r}) + 39'(dy);

  always_comb begin
    sx_v = sat_pos(nx, cx);
    sy_v = sat_pos(ny, cy);
    qz   = to_q15(cor_sin);
    qw   = to_q15(cor_cos);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (pop && item.op == OP_SAMPLE) begin
          st_nxt = skip_r ? S_HALFS : S_ARC1;
        end
      end
      S_ARC1:  st_nxt = S_ARC2;
      S_ARC2:  st_nxt = S_GAIN;
      S_GAIN:  st_nxt = S_RAD1;
      S_RAD1:  st_nxt = S_RAD2;
      S_RAD2:  st_nxt = S_ROTS;
      S_ROTS:  st_nxt = S_ROTW;
      S_ROTW: begin
        if (cor_stat.done) begin
          st_nxt = S_MOVE;
        end
      end
      S_MOVE:  st_nxt = S_SATS;
      S_SATS:  st_nxt = S_HALFS;
      S_HALFS: st_nxt = S_HALFW;
      S_HALFW: begin
        if (cor_stat.done) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pos_x_r     <= POS_X_RST;
      pos_y_r     <= POS_Y_RST;
      heading_r   <= HEADING_RST;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      moved_r     <= 1'b0;
      clip_r      <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (pop) begin
            if (item.op == OP_CORRECT) begin
              pos_x_r   <= item.a;
              pos_y_r   <= item.b;
              heading_r <= item.c;
              skip_r    <= 1'b1;
            end else begin
              skip_r  <= 1'b0;
              moved_r <= !skip_r;
              clip_r  <= 1'b0;
            end
          end
        end
        S_RAD2: heading_r <= head_nxt;
        S_SATS: begin
          pos_x_r <= sx_v;
          pos_y_r <= sy_v;
          clip_r  <= cx || cy;
        end
        S_HALFW: begin
          if (cor_stat.done) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      spd_l_r <= item.a;
      spd_r_r <= item.b;
    end
    pl_r   <= $signed(spd_l_r) * $signed({1'b0, wheel_radius});
    pr_r   <= $signed(spd_r_r) * $signed({1'b0, wheel_radius});
    al_r   <= tl[65:32];
    ar_r   <= tr[65:32];
    if (st_r == S_GAIN) begin
      mean_r <= sum_lr[34:1];
      neg_r  <= diff_lr[34];
      rad_r  <= mprod[63:16];
    end
    plo_r  <= rad_r[23:0] * RAD_TO_BAM;
    phi_r  <= rad_r[47:24] * RAD_TO_BAM;
    if (st_r == S_MOVE) begin
      mx_r <= 68'(mean_r) * 68'(cor_cos);
      my_r <= 68'(mean_r) * 68'(cor_sin);
    end
    if (st_r == S_HALFW && cor_stat.done) begin
      o_x_r   <= pos_x_r;
      o_y_r   <= pos_y_r;
      o_h_r   <= heading_r;
      o_z_r   <= qz;
      o_w_r   <= qw;
      o_int_r <= moved_r;
      o_sat_r <= clip_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pose_x         = o_x_r;
  assign out_pose_y         = o_y_r;
  assign out_pose_heading   = o_h_r;
  assign out_quat_z         = o_z_r;
  assign out_quat_w         = o_w_r;
  assign out_was_integrated = o_int_r;
  assign out_saturated      = o_sat_r;

  `ODO_ASSERT_IMP(a_skip_no_clip, out_valid_r && !o_int_r, !o_sat_r, "skipped sample clipped")
  `ODO_ASSERT_IMP(a_cordic_free, cor_start, !cor_stat.busy, "CORDIC restarted while busy")
  `ODO_ASSERT_NXT(a_corr_arms, pop && item.op == OP_CORRECT, skip_r, "correction left no skip")

endmodule
